>>> rtl/core/two_layer_pointwise_conv_defines.svh
// Assertion macros for the top-level RTL module.
`ifndef TWO_LAYER_POINTWISE_CONV_DEFINES_SVH
`define TWO_LAYER_POINTWISE_CONV_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define TPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tpc_pkg.sv
package tpc_pkg;
  localparam int unsigned MaxChannelsDef = 128;
  localparam int unsigned PixelsDef = 64;
  localparam int unsigned OutBlockDef = 32;
  localparam int unsigned InUnrollDef = 16;
  localparam logic [14:0] SatMax = 15'd32767;

  localparam logic [2:0] FUNC_WR_FEAT = 3'd0;
  localparam logic [2:0] FUNC_WR_W1 = 3'd1;
  localparam logic [2:0] FUNC_WR_W2 = 3'd2;
  localparam logic [2:0] FUNC_RUN = 3'd3;
  localparam logic [2:0] FUNC_READ = 3'd4;

  localparam logic [2:0] CFG_IN_CH = 3'd0;
  localparam logic [2:0] CFG_MID_CH = 3'd1;
  localparam logic [2:0] CFG_OUT_CH = 3'd2;
  localparam logic [2:0] CFG_SHIFT1 = 3'd3;
  localparam logic [2:0] CFG_SHIFT2 = 3'd4;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  function automatic logic [14:0] relu_sat(input logic [31:0] acc, input logic [4:0] sh);
    logic [31:0] r;
    r = acc >> sh;
    if (acc[31]) begin
      relu_sat = 15'd0;
    end else if (r > 32'(SatMax)) begin
      relu_sat = SatMax;
    end else begin
      relu_sat = r[14:0];
    end
  endfunction
endpackage

>>> rtl/core/tpc_ram.sv
module tpc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/two_layer_pointwise_conv.sv
// Loads and unused codes finish in idle; a read goes through READ, then its result is registered.
// A run computes each layer in blocks of OUT_BLOCK output channels per pixel, with
// one multiply-accumulate per cycle against the weight memory and the layer's source memory.
// One request is in work at a time; a result register holds the answer until it is taken.
// Synchronous active-low reset restores the configuration defaults and idles the control;
// the feature and weight memories are not cleared.
module two_layer_pointwise_conv #(
  parameter int unsigned MAX_CHANNELS = tpc_pkg::MaxChannelsDef,
  parameter int unsigned PIXELS = tpc_pkg::PixelsDef,
  parameter int unsigned OUT_BLOCK = tpc_pkg::OutBlockDef,
  parameter int unsigned IN_UNROLL = tpc_pkg::InUnrollDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [6:0]  in_row_index,
  input  logic [6:0]  in_col_index,
  input  logic signed [15:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [14:0] out_read_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tpc_pkg::*;
`include "two_layer_pointwise_conv_defines.svh"

  localparam int unsigned CW = $clog2(MAX_CHANNELS);
  localparam int unsigned PW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned OW = (OUT_BLOCK > 1) ? $clog2(OUT_BLOCK) : 1;
  localparam int unsigned FD = MAX_CHANNELS * PIXELS;
  localparam int unsigned WD = MAX_CHANNELS * MAX_CHANNELS;
  localparam int unsigned FAW = $clog2(FD);
  localparam int unsigned WAW = $clog2(WD);
  localparam int unsigned NW = CW + 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MAC, S_DRAIN, S_STORE, S_RESP} state_t;

  state_t state_r;
  logic [7:0] in_ch_r, mid_ch_r, out_ch_r;
  logic [4:0] sh1_r, sh2_r;
  logic out_valid_r, out_kind_r;
  logic [14:0] out_val_r;
  logic rd_ok_r;

  logic layer_r;
  logic [NW-1:0] ob_r, nin_r, nout_r;
  logic [PW-1:0] pix_r;
  logic [OW-1:0] lane_r;
  logic [CW-1:0] ich_r;
  logic mac_v_r, mac_v2_r, last_v_r, last_v2_r;
  logic [OW-1:0] lane_d_r, lane_d2_r;
  logic [31:0] prod_r;
  logic [31:0] acc_r [OUT_BLOCK];

  // Memory ports.
  logic feat_we, w1_we, w2_we, mid_we, of_we;
  logic [FAW-1:0] feat_wa, feat_ra, mid_wa, mid_ra, of_wa, of_ra;
  logic [WAW-1:0] w_wa, w_ra;
  logic [15:0] feat_rd, w1_rd, w2_rd, mid_rd, of_rd, res_wd;

  tpc_ram #(.WIDTH(16), .DEPTH(FD)) u_feat (.clk, .we(feat_we), .waddr(feat_wa),
    .wdata(in_value), .raddr(feat_ra), .rdata(feat_rd));
  tpc_ram #(.WIDTH(16), .DEPTH(WD)) u_w1 (.clk, .we(w1_we), .waddr(w_wa),
    .wdata(in_value), .raddr(w_ra), .rdata(w1_rd));
  tpc_ram #(.WIDTH(16), .DEPTH(WD)) u_w2 (.clk, .we(w2_we), .waddr(w_wa),
    .wdata(in_value), .raddr(w_ra), .rdata(w2_rd));
  tpc_ram #(.WIDTH(16), .DEPTH(FD)) u_mid (.clk, .we(mid_we), .waddr(mid_wa),
    .wdata(res_wd), .raddr(mid_ra), .rdata(mid_rd));
  tpc_ram #(.WIDTH(16), .DEPTH(FD)) u_of (.clk, .we(of_we), .waddr(of_wa),
    .wdata(res_wd), .raddr(of_ra), .rdata(of_rd));

  logic in_fire, row_ok, pix_ok, col_ok;
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_read_value = out_val_r;

  assign row_ok = 32'(in_row_index) < MAX_CHANNELS;
  assign col_ok = 32'(in_col_index) < MAX_CHANNELS;
  assign pix_ok = 32'(in_col_index) < PIXELS;

  assign feat_we = in_fire && in_func == FUNC_WR_FEAT && row_ok && pix_ok;
  assign w1_we = in_fire && in_func == FUNC_WR_W1 && row_ok && col_ok;
  assign w2_we = in_fire && in_func == FUNC_WR_W2 && row_ok && col_ok;
  assign feat_wa = FAW'(32'(in_row_index) * PIXELS + 32'(in_col_index));
  assign w_wa = WAW'(32'(in_row_index) * MAX_CHANNELS + 32'(in_col_index));

  // Compute read addresses: weight[ob+lane][ich], source[ich][pix].
  logic [31:0] cur_ch;
  assign cur_ch = 32'(ob_r) + 32'(lane_r);
  assign w_ra = WAW'(cur_ch * MAX_CHANNELS + 32'(ich_r));
  assign feat_ra = FAW'(32'(ich_r) * PIXELS + 32'(pix_r));
  assign mid_ra = feat_ra;
  assign of_ra = feat_wa;

  logic [15:0] src_rd, wt_rd;
  logic signed [31:0] prod_full;
  assign src_rd = layer_r ? mid_rd : feat_rd;
  assign wt_rd = layer_r ? w2_rd : w1_rd;
  assign prod_full = $signed(src_rd) * $signed(wt_rd);

  // Writeback during STORE: lane_r walks the block.
  logic st_ok;
  assign st_ok = (state_r == S_STORE) && (cur_ch < MAX_CHANNELS);
  assign res_wd = {1'b0, relu_sat(acc_r[lane_r], layer_r ? sh2_r : sh1_r)};
  assign mid_we = st_ok && !layer_r;
  assign of_we = st_ok && layer_r;
  assign mid_wa = FAW'(cur_ch * PIXELS + 32'(pix_r));
  assign of_wa = mid_wa;

  // Rounding down is a mask, so the block sizes must be powers of two; the module does not enforce this.
  function automatic logic [NW-1:0] rnd(input logic [7:0] c, input int unsigned step);
    int unsigned v;
    v = (32'(c) > MAX_CHANNELS) ? MAX_CHANNELS : 32'(c);
    rnd = NW'(v & ~(step - 1));
  endfunction

  logic [NW-1:0] n_in, n_mid, n_mid_in, n_out;
  assign n_in = rnd(in_ch_r, IN_UNROLL);
  assign n_mid = rnd(mid_ch_r, OUT_BLOCK);
  assign n_mid_in = NW'(32'(n_mid) & ~32'(IN_UNROLL - 1));
  assign n_out = rnd(out_ch_r, OUT_BLOCK);

  logic mac_last;
  assign mac_last = (32'(ich_r) + 1 >= 32'(nin_r)) && (32'(lane_r) == OUT_BLOCK - 1);

  always_ff @(posedge clk) begin
    prod_r <= prod_full;
    lane_d_r <= lane_r;
    lane_d2_r <= lane_d_r;
    if (!rst_n) begin
      state_r <= S_IDLE;
      in_ch_r <= 8'd128;
      mid_ch_r <= 8'd128;
      out_ch_r <= 8'd128;
      sh1_r <= 5'd8;
      sh2_r <= 5'd8;
      out_valid_r <= 1'b0;
      out_kind_r <= KIND_READ;
      out_val_r <= '0;
      rd_ok_r <= 1'b0;
      layer_r <= 1'b0;
      ob_r <= '0;
      nin_r <= '0;
      nout_r <= '0;
      pix_r <= '0;
      lane_r <= '0;
      ich_r <= '0;
      mac_v_r <= 1'b0;
      mac_v2_r <= 1'b0;
      last_v_r <= 1'b0;
      last_v2_r <= 1'b0;
      for (int k = 0; k < OUT_BLOCK; k++) acc_r[k] <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_IN_CH:  in_ch_r <= cfg_data;
          CFG_MID_CH: mid_ch_r <= cfg_data;
          CFG_OUT_CH: out_ch_r <= cfg_data;
          CFG_SHIFT1: sh1_r <= cfg_data[4:0];
          CFG_SHIFT2: sh2_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      mac_v2_r <= mac_v_r;
      last_v2_r <= last_v_r;
      mac_v_r <= 1'b0;
      last_v_r <= 1'b0;
      if (mac_v2_r) acc_r[lane_d2_r] <= acc_r[lane_d2_r] + prod_r;
      case (state_r)
        S_IDLE: begin
          if (in_fire && in_func == FUNC_READ) begin
            state_r <= S_READ;
            rd_ok_r <= row_ok && pix_ok;
          end else if (in_fire && in_func == FUNC_RUN) begin
            layer_r <= 1'b0;
            ob_r <= '0;
            pix_r <= '0;
            lane_r <= '0;
            ich_r <= '0;
            nin_r <= n_in;
            nout_r <= n_mid;
            for (int k = 0; k < OUT_BLOCK; k++) acc_r[k] <= '0;
            state_r <= (n_mid == '0) ? S_DRAIN : ((n_in == '0) ? S_STORE : S_MAC);
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          out_kind_r <= KIND_READ;
          out_val_r <= rd_ok_r ? of_rd[14:0] : 15'd0;
          state_r <= S_IDLE;
        end
        S_MAC: begin
          mac_v_r <= 1'b1;
          last_v_r <= mac_last;
          if (32'(ich_r) + 1 >= 32'(nin_r)) begin
            ich_r <= '0;
            lane_r <= OW'(32'(lane_r) + 1);
          end else begin
            ich_r <= CW'(32'(ich_r) + 1);
          end
          if (mac_last) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          lane_r <= '0;
          if (nin_r == '0 || nout_r == '0) begin
            state_r <= S_RESP;
          end else if (last_v2_r) begin
            state_r <= S_STORE;
          end
        end
        S_STORE: begin
          if (32'(lane_r) == OUT_BLOCK - 1) begin
            lane_r <= '0;
            for (int k = 0; k < OUT_BLOCK; k++) acc_r[k] <= '0;
            if (32'(pix_r) == PIXELS - 1) begin
              pix_r <= '0;
              if (32'(ob_r) + OUT_BLOCK >= 32'(nout_r)) begin
                state_r <= S_RESP;
              end else begin
                ob_r <= NW'(32'(ob_r) + OUT_BLOCK);
                state_r <= (nin_r == '0) ? S_STORE : S_MAC;
              end
            end else begin
              pix_r <= PW'(32'(pix_r) + 1);
              state_r <= (nin_r == '0) ? S_STORE : S_MAC;
            end
          end else begin
            lane_r <= OW'(32'(lane_r) + 1);
          end
        end
        S_RESP: begin
          if (!layer_r) begin
            layer_r <= 1'b1;
            ob_r <= '0;
            pix_r <= '0;
            lane_r <= '0;
            ich_r <= '0;
            nin_r <= n_mid_in;
            nout_r <= n_out;
            state_r <= (n_out == '0) ? S_DRAIN : ((n_mid_in == '0) ? S_STORE : S_MAC);
          end else begin
            out_valid_r <= 1'b1;
            out_kind_r <= KIND_DONE;
            out_val_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `TPC_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !in_ready, "accept while busy")
  `TPC_ASSERT_NXT(a_read_then_result, state_r == S_READ, out_valid && out_kind == KIND_READ,
    "read did not produce a result")
  `TPC_ASSERT_IMP(a_done_zero, out_valid && out_kind == KIND_DONE, out_read_value == 15'd0,
    "run result carries data")
endmodule
